// File: design/plst_pkg.sv
package plst_pkg;

  // Fixed widths of the item fields.
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned CNT_OUT_W = 7;

  // Defaults for the top level parameters.
  localparam int unsigned DEF_CAPACITY   = 64;
  localparam int unsigned DEF_DATA_WIDTH = 32;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]      status;
    logic                 found;
    logic [CNT_OUT_W-1:0] count_now;
  } rsp_t;

endpackage

// File: design/positional_list_store.sv
// Channel   Ports                       Handshake
// request   start, busy, in_req         item taken at a rising edge with start high, busy low
// result    out_valid, out_rsp          one-cycle strobe, taken at the edge that ends it
//
// An item visits its live entries between acceptance and the result strobe, through the
// single memory port: a search reads every live entry, an insert moves the entry at the
// position and each entry behind it once, a delete moves each entry behind the position
// once, one entry per cycle, with read and write of neighboring entries overlapped.
// Reset (synchronous, rst_n low) empties the list; the entry memory itself is not cleared.
// The receiver cannot stall: the result is offered for exactly one cycle.

module positional_list_store
  import plst_pkg::*;
#(
  parameter int unsigned CAPACITY   = DEF_CAPACITY,
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  req_t in_req,
  output logic busy,
  output logic out_valid,
  output rsp_t out_rsp
);

  localparam int unsigned AW = $clog2(CAPACITY);

  // Memory port between the sequencer and the entry store.
  logic                  mem_rd_en;
  logic [AW-1:0]         mem_rd_addr;
  logic [DATA_WIDTH-1:0] mem_rd_data;
  logic                  mem_wr_en;
  logic [AW-1:0]         mem_wr_addr;
  logic [DATA_WIDTH-1:0] mem_wr_data;

  // The sequencer validates each request, then walks the live entries through the
  // one memory port: a scan for search, a shift toward the tail for insert and a
  // shift toward the head for delete. The result is registered when the walk ends.
  plst_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req      (in_req),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_rsp     (out_rsp),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  // Entry store: one write and one registered read per cycle. Only live entries are
  // ever read, so it needs no clearing after reset.
  plst_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

endmodule

// File: design/plst_mem.sv
module plst_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/plst_ctrl.sv
module plst_ctrl
  import plst_pkg::*;
#(
  parameter int unsigned CAPACITY   = DEF_CAPACITY,
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  req_t                        in_req,
  output logic                        busy,
  output logic                        out_valid,
  output rsp_t                        out_rsp,
  output logic                        mem_rd_en,
  output logic [$clog2(CAPACITY)-1:0] mem_rd_addr,
  input  logic [DATA_WIDTH-1:0]       mem_rd_data,
  output logic                        mem_wr_en,
  output logic [$clog2(CAPACITY)-1:0] mem_wr_addr,
  output logic [DATA_WIDTH-1:0]       mem_wr_data
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_t;

  state_t                 state_r, state_nxt;
  logic [REQ_W-1:0]       op_r, op_nxt;
  logic                   ok_r, ok_nxt;
  logic [ST_W-1:0]        status_r, status_nxt;
  logic                   found_r, found_nxt;
  logic [DATA_WIDTH-1:0]  val_r, val_nxt;
  logic [AW-1:0]          rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]          rd_left_r, rd_left_nxt;
  logic                   pend_r, pend_nxt;
  logic [AW-1:0]          pend_addr_r, pend_addr_nxt;
  logic [AW-1:0]          ins_addr_r, ins_addr_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   out_valid_r, out_valid_nxt;
  rsp_t                   out_rsp_r, out_rsp_nxt;

  // Request decode at acceptance.
  logic [LW-1:0]   pos_x, cnt_x, reads_x, start_x;
  logic [ST_W-1:0] acc_status;
  logic            acc_ok;
  logic            full;

  always_comb begin
    pos_x      = LW'(in_req.position);
    cnt_x      = LW'(count_r);
    full       = (count_r == CW'(CAPACITY));
    acc_status = ST_OK;
    acc_ok     = 1'b0;
    reads_x    = '0;
    start_x    = '0;
    unique case (in_req.req_type)
      REQ_INSERT: begin
        start_x = cnt_x - LW'(1);
        if (full) begin
          acc_status = ST_FULL;
        end else if (pos_x == '0 || pos_x > cnt_x + LW'(1)) begin
          acc_status = ST_RANGE;
        end else begin
          acc_ok  = 1'b1;
          reads_x = cnt_x + LW'(1) - pos_x;
        end
      end
      REQ_DELETE: begin
        start_x = pos_x;
        if (pos_x == '0 || pos_x > cnt_x) begin
          acc_status = ST_RANGE;
        end else begin
          acc_ok  = 1'b1;
          reads_x = cnt_x - pos_x;
        end
      end
      REQ_SEARCH: begin
        reads_x = cnt_x;
      end
      default: begin
        acc_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    ok_nxt        = ok_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    val_nxt       = val_r;
    rd_idx_nxt    = rd_idx_r;
    rd_left_nxt   = rd_left_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    ins_addr_nxt  = ins_addr_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = rd_idx_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = '0;
    mem_wr_data   = val_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt    = S_RUN;
          op_nxt       = in_req.req_type;
          ok_nxt       = acc_ok;
          status_nxt   = acc_status;
          found_nxt    = 1'b0;
          val_nxt      = DATA_WIDTH'(in_req.value);
          rd_idx_nxt   = start_x[AW-1:0];
          rd_left_nxt  = reads_x[CW-1:0];
          ins_addr_nxt = AW'(pos_x - LW'(1));
        end
      end
      S_RUN: begin
        // Issue the next read of the scan.
        if (rd_left_r != '0) begin
          mem_rd_en     = 1'b1;
          pend_nxt      = 1'b1;
          pend_addr_nxt = rd_idx_r;
          rd_left_nxt   = rd_left_r - CW'(1);
          rd_idx_nxt    = (op_r == REQ_INSERT) ? rd_idx_r - AW'(1) : rd_idx_r + AW'(1);
        end else begin
          state_nxt = S_FIN;
        end
        // Consume the read issued in the previous cycle.
        if (pend_r) begin
          case (op_r)
            REQ_INSERT: begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = pend_addr_r + AW'(1);
              mem_wr_data = mem_rd_data;
            end
            REQ_DELETE: begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = pend_addr_r - AW'(1);
              mem_wr_data = mem_rd_data;
            end
            default: begin
              if (mem_rd_data == val_r) begin
                found_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      S_FIN: begin
        state_nxt = S_IDLE;
        if (ok_r && op_r == REQ_INSERT) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = ins_addr_r;
          mem_wr_data = val_r;
          count_nxt   = count_r + CW'(1);
        end else if (ok_r && op_r == REQ_DELETE) begin
          count_nxt = count_r - CW'(1);
        end
        out_valid_nxt         = 1'b1;
        out_rsp_nxt.status    = status_r;
        out_rsp_nxt.found     = found_r;
        out_rsp_nxt.count_now = CNT_OUT_W'(count_nxt);
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    ok_r        <= ok_nxt;
    status_r    <= status_nxt;
    found_r     <= found_nxt;
    val_r       <= val_nxt;
    rd_idx_r    <= rd_idx_nxt;
    rd_left_r   <= rd_left_nxt;
    pend_addr_r <= pend_addr_nxt;
    ins_addr_r  <= ins_addr_nxt;
    out_rsp_r   <= out_rsp_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// File: design/plst_checker.sv
module plst_checker
  import plst_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input rsp_t out_rsp
);

  // An accepted item keeps the block busy for at least the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted item");

  // The result strobe appears exactly when the block returns to idle.
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(busy) && !busy |-> out_valid)
    else $error("block went idle without a result");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.found |-> out_rsp.status == ST_OK)
    else $error("found set on a rejected request");

endmodule

bind positional_list_store plst_checker u_plst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);
